@@ design/fibonacci_matrix_power_mod_macros.svh @@
// Assertion macros shared by the Fibonacci matrix power modules.
`ifndef FIBONACCI_MATRIX_POWER_MOD_MACROS_SVH
`define FIBONACCI_MATRIX_POWER_MOD_MACROS_SVH
`ifndef SYNTHESIS
`define FMPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FMPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FMPM_ASSERT(lbl, prop, msg)
`define FMPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/fmpm_pkg.sv @@
// Types, constants and microcode program of the Fibonacci matrix power block.
package fmpm_pkg;

  localparam int INDEX_BITS   = 63;
  localparam int MOD_BITS     = 30;
  localparam int MOD_REG_BITS = 31;
  localparam int PROD_BITS    = 2 * MOD_BITS;
  localparam int DATA_BITS    = 32;
  localparam int REG_IDX_BITS = 1;
  localparam int PADDR_BITS   = REG_IDX_BITS + 2;

  localparam logic [REG_IDX_BITS-1:0] REG_MODULUS = REG_IDX_BITS'(0);

  localparam logic [MOD_REG_BITS-1:0] MODULUS_RESET = MOD_REG_BITS'(998244352);
  localparam logic [MOD_REG_BITS-1:0] MOD_LIMIT     = MOD_REG_BITS'(1) << MOD_BITS;
  localparam logic [MOD_REG_BITS-1:0] MOD_MIN       = MOD_REG_BITS'(2);

  // remainder unit: radix-16 restoring remainder over a 64-bit sum of two products
  localparam int RED_BITS     = 64;
  localparam int RED_RADIX    = 4;
  localparam int RED_STEPS    = RED_BITS / RED_RADIX;
  localparam int RED_CNT_BITS = $clog2(RED_STEPS);

  // symmetric 2x2 matrix [[a,b],[b,c]]
  typedef struct packed {
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
    logic [MOD_BITS-1:0] c;
  } fmpm_mat_t;

  localparam fmpm_mat_t MAT_IDENT = '{a: MOD_BITS'(1), b: MOD_BITS'(0), c: MOD_BITS'(1)};
  localparam fmpm_mat_t MAT_STEP  = '{a: MOD_BITS'(1), b: MOD_BITS'(1), c: MOD_BITS'(0)};

  typedef enum logic [1:0] {ENT_A, ENT_B, ENT_C} ent_e;
  typedef enum logic [1:0] {COPY_NONE, COPY_ACC, COPY_BASE} copy_e;
  typedef enum logic [2:0] {
    COND_NEXT, COND_ALWAYS, COND_WAIT, COND_SPECIAL, COND_NOT_P0, COND_P_LAST, COND_RED_MORE
  } cond_e;

  localparam int UPC_BITS = 6;

  typedef struct packed {
    logic                x_base;
    ent_e                x_idx;
    logic                y_base;
    ent_e                y_idx;
    logic                mul_en;
    logic                hold_en;
    logic                red_load;
    logic                red_run;
    logic                t_wr;
    ent_e                t_idx;
    copy_e               copy;
    logic                p_shift;
    logic                fin;
    cond_e               cond;
    logic [UPC_BITS-1:0] target;
  } fmpm_ctrl_t;

  typedef struct packed {
    logic special;
    logic p0;
    logic p_last;
    logic red_more;
  } fmpm_stat_t;

  localparam fmpm_ctrl_t CTRL_NOP = '0;

  // program layout
  localparam int SECT_LEN  = 14;
  localparam logic [UPC_BITS-1:0] S_IDLE    = UPC_BITS'(0);
  localparam logic [UPC_BITS-1:0] S_CHECK   = UPC_BITS'(1);
  localparam logic [UPC_BITS-1:0] S_LOOP    = UPC_BITS'(2);
  localparam logic [UPC_BITS-1:0] MUL_FIRST = UPC_BITS'(3);
  localparam logic [UPC_BITS-1:0] MUL_LAST  = UPC_BITS'(3 + SECT_LEN - 1);
  localparam logic [UPC_BITS-1:0] S_SQ      = UPC_BITS'(3 + SECT_LEN);
  localparam logic [UPC_BITS-1:0] SQ_FIRST  = UPC_BITS'(4 + SECT_LEN);
  localparam logic [UPC_BITS-1:0] SQ_LAST   = UPC_BITS'(4 + 2 * SECT_LEN - 1);
  localparam logic [UPC_BITS-1:0] S_FIN     = UPC_BITS'(4 + 2 * SECT_LEN);

  localparam logic [3:0] SECT_COPY  = 4'd13;
  localparam logic [1:0] ENT_WRLAST = 2'd3;
  localparam logic [1:0] PH_MUL0    = 2'd0;
  localparam logic [1:0] PH_MUL1    = 2'd1;
  localparam logic [1:0] PH_LOAD    = 2'd2;
  localparam logic [1:0] PH_RUN     = 2'd3;

  function automatic fmpm_mat_t mat_put(input fmpm_mat_t m, input ent_e idx,
                                        input logic [MOD_BITS-1:0] v);
    fmpm_mat_t r;
    r = m;
    case (idx)
      ENT_A:   r.a = v;
      ENT_B:   r.b = v;
      ENT_C:   r.c = v;
      default: r = m;
    endcase
    return r;
  endfunction

  function automatic logic [MOD_BITS-1:0] mat_get(input fmpm_mat_t m, input ent_e idx);
    logic [MOD_BITS-1:0] v;
    case (idx)
      ENT_A:   v = m.a;
      ENT_B:   v = m.b;
      ENT_C:   v = m.c;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One section computes a product X*Y of symmetric matrices, entry by entry:
  //   a = Xa*Ya + Xb*Yb, b = Xa*Yb + Xb*Yc, c = Xb*Yb + Xc*Yc
  function automatic fmpm_ctrl_t sect_word(input logic [UPC_BITS-1:0] step,
                                           input logic [UPC_BITS-1:0] first,
                                           input logic sq);
    fmpm_ctrl_t w;
    logic [UPC_BITS-1:0] off;
    logic [1:0] entry;
    logic [1:0] phase;
    w     = CTRL_NOP;
    off   = step - first;
    entry = off[3:2];
    phase = off[1:0];
    w.x_base = sq;
    w.y_base = 1'b1;
    if (off[3:0] == SECT_COPY) begin
      w.copy = sq ? COPY_BASE : COPY_ACC;
      if (sq) begin
        w.p_shift = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = S_LOOP;
      end
    end else if (entry == ENT_WRLAST) begin
      w.t_wr  = 1'b1;
      w.t_idx = ENT_C;
    end else begin
      case (phase)
        PH_MUL0: begin
          w.mul_en = 1'b1;
          case (entry)
            2'd0:    begin w.x_idx = ENT_A; w.y_idx = ENT_A; end
            2'd1:    begin w.x_idx = ENT_A; w.y_idx = ENT_B; w.t_wr = 1'b1; w.t_idx = ENT_A; end
            default: begin w.x_idx = ENT_B; w.y_idx = ENT_B; w.t_wr = 1'b1; w.t_idx = ENT_B; end
          endcase
        end
        PH_MUL1: begin
          w.mul_en  = 1'b1;
          w.hold_en = 1'b1;
          case (entry)
            2'd0:    begin w.x_idx = ENT_B; w.y_idx = ENT_B; end
            2'd1:    begin w.x_idx = ENT_B; w.y_idx = ENT_C; end
            default: begin w.x_idx = ENT_C; w.y_idx = ENT_C; end
          endcase
        end
        PH_LOAD: w.red_load = 1'b1;
        default: begin
          w.red_run = 1'b1;
          w.cond    = COND_RED_MORE;
          w.target  = step;
        end
      endcase
    end
    return w;
  endfunction

  function automatic fmpm_ctrl_t ucode(input logic [UPC_BITS-1:0] step);
    fmpm_ctrl_t w;
    w = CTRL_NOP;
    case (step) inside
      S_IDLE:  begin w.cond = COND_WAIT;    w.target = S_IDLE; end
      S_CHECK: begin w.cond = COND_SPECIAL; w.target = S_FIN;  end
      S_LOOP:  begin w.cond = COND_NOT_P0;  w.target = S_SQ;   end
      S_SQ:    begin w.cond = COND_P_LAST;  w.target = S_FIN;  end
      S_FIN:   begin w.fin = 1'b1; w.cond = COND_ALWAYS; w.target = S_IDLE; end
      [MUL_FIRST:MUL_LAST]: w = sect_word(step, MUL_FIRST, 1'b0);
      [SQ_FIRST:SQ_LAST]:   w = sect_word(step, SQ_FIRST, 1'b1);
      default: begin w.cond = COND_ALWAYS; w.target = S_IDLE; end
    endcase
    return w;
  endfunction

endpackage

@@ design/fmpm_reduce.sv @@
// Multi-cycle remainder unit: 64-bit value modulo a 31-bit modulus, four bits a cycle while run_i is high.
`include "fibonacci_matrix_power_mod_macros.svh"

module fmpm_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic                              run_i,
  input  logic [fmpm_pkg::RED_BITS-1:0]     x_i,
  input  logic [fmpm_pkg::MOD_REG_BITS-1:0] m_i,
  output logic [fmpm_pkg::MOD_BITS-1:0]     rem_o,
  output logic                              more_o
);

  logic [fmpm_pkg::RED_BITS-1:0]     x_q, x_d;
  logic [fmpm_pkg::MOD_BITS-1:0]     r_q, r_d;
  logic [fmpm_pkg::RED_CNT_BITS-1:0] cnt_q;
  logic [fmpm_pkg::MOD_REG_BITS-1:0] trial;

  // restoring remainder, MSB first; r stays below m so {r, bit} fits 31 bits
  always_comb begin
    r_d   = r_q;
    x_d   = x_q << fmpm_pkg::RED_RADIX;
    trial = '0;
    for (int j = 0; j < fmpm_pkg::RED_RADIX; j++) begin
      trial = {r_d, x_q[fmpm_pkg::RED_BITS-1-j]};
      if (trial >= m_i) begin
        trial = trial - m_i;
      end
      r_d = trial[fmpm_pkg::MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= x_i;
      r_q <= '0;
    end else if (run_i) begin
      x_q <= x_d;
      r_q <= r_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (run_i) begin
      cnt_q <= cnt_q + fmpm_pkg::RED_CNT_BITS'(1);
    end
  end

  assign rem_o  = r_q;
  assign more_o = (cnt_q != fmpm_pkg::RED_CNT_BITS'(fmpm_pkg::RED_STEPS - 1));

  `FMPM_ASSERT_NEXT(a_rem_below_mod, run_i, {1'b0, rem_o} < m_i, "remainder not below modulus")

endmodule

@@ design/fmpm_datapath.sv @@
// Matrix registers, shared multiplier and remainder unit driven by the control word.
`include "fibonacci_matrix_power_mod_macros.svh"

module fmpm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fmpm_pkg::fmpm_ctrl_t                ctrl_i,
  input  logic                                accept_i,
  input  logic [fmpm_pkg::INDEX_BITS-1:0]     index_i,
  input  logic [fmpm_pkg::MOD_REG_BITS-1:0]   modulus_i,
  output fmpm_pkg::fmpm_stat_t                stat_o,
  output logic                                done_o,
  output logic [fmpm_pkg::MOD_BITS-1:0]       fib_value_o
);

  logic [fmpm_pkg::MOD_REG_BITS-1:0] m_q, m_eff;
  logic [fmpm_pkg::INDEX_BITS-1:0]   p_q;
  logic                              special_q, one_q;
  fmpm_pkg::fmpm_mat_t               acc_q, base_q, t_q, x_mat, y_mat;
  logic [fmpm_pkg::MOD_BITS-1:0]     opx, opy, rem;
  logic [fmpm_pkg::PROD_BITS-1:0]    prod_q, prod_d, hold_q;
  logic [fmpm_pkg::RED_BITS-1:0]     red_x;
  logic                              red_more;
  logic                              done_q;
  logic [fmpm_pkg::MOD_BITS-1:0]     fib_q;

  // modulus above 2^30 saturates
  assign m_eff = (modulus_i > fmpm_pkg::MOD_LIMIT) ? fmpm_pkg::MOD_LIMIT : modulus_i;

  assign x_mat  = ctrl_i.x_base ? base_q : acc_q;
  assign y_mat  = ctrl_i.y_base ? base_q : acc_q;
  assign opx    = fmpm_pkg::mat_get(x_mat, ctrl_i.x_idx);
  assign opy    = fmpm_pkg::mat_get(y_mat, ctrl_i.y_idx);
  assign prod_d = fmpm_pkg::PROD_BITS'(opx) * fmpm_pkg::PROD_BITS'(opy);
  assign red_x  = fmpm_pkg::RED_BITS'(hold_q) + fmpm_pkg::RED_BITS'(prod_q);

  fmpm_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctrl_i.red_load),
    .run_i  (ctrl_i.red_run),
    .x_i    (red_x),
    .m_i    (m_q),
    .rem_o  (rem),
    .more_o (red_more)
  );

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      m_q    <= m_eff;
      p_q    <= index_i - fmpm_pkg::INDEX_BITS'(1);
      one_q  <= (m_eff >= fmpm_pkg::MOD_MIN) && (index_i == fmpm_pkg::INDEX_BITS'(1));
      acc_q  <= fmpm_pkg::MAT_IDENT;
      base_q <= fmpm_pkg::MAT_STEP;
    end else begin
      if (ctrl_i.p_shift) begin
        p_q <= p_q >> 1;
      end
      if (ctrl_i.copy == fmpm_pkg::COPY_ACC) begin
        acc_q <= t_q;
      end
      if (ctrl_i.copy == fmpm_pkg::COPY_BASE) begin
        base_q <= t_q;
      end
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.hold_en) begin
      hold_q <= prod_q;
    end
    if (ctrl_i.t_wr) begin
      t_q <= fmpm_pkg::mat_put(t_q, ctrl_i.t_idx, rem);
    end
    if (ctrl_i.fin) begin
      fib_q <= special_q ? fmpm_pkg::MOD_BITS'(one_q) : acc_q.a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (accept_i) begin
        special_q <= (m_eff < fmpm_pkg::MOD_MIN) || (index_i < fmpm_pkg::INDEX_BITS'(2));
      end
      done_q <= ctrl_i.fin;
    end
  end

  assign stat_o.special  = special_q;
  assign stat_o.p0       = p_q[0];
  assign stat_o.p_last   = ((p_q >> 1) == '0);
  assign stat_o.red_more = red_more;
  assign done_o          = done_q;
  assign fib_value_o     = fib_q;

  `FMPM_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")

endmodule

@@ design/fmpm_seq.sv @@
// Microcode sequencer: step counter, program table lookup and conditional jumps.
`include "fibonacci_matrix_power_mod_macros.svh"

module fmpm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  fmpm_pkg::fmpm_stat_t stat_i,
  output fmpm_pkg::fmpm_ctrl_t ctrl_o,
  output logic                 accept_o,
  output logic                 busy_o
);

  logic [fmpm_pkg::UPC_BITS-1:0] upc_q, upc_d;
  logic                          take;

  assign ctrl_o   = fmpm_pkg::ucode(upc_q);
  assign busy_o   = (upc_q != fmpm_pkg::S_IDLE);
  assign accept_o = start_i && !busy_o;

  always_comb begin
    case (ctrl_o.cond)
      fmpm_pkg::COND_NEXT:     take = 1'b0;
      fmpm_pkg::COND_ALWAYS:   take = 1'b1;
      fmpm_pkg::COND_WAIT:     take = !start_i;
      fmpm_pkg::COND_SPECIAL:  take = stat_i.special;
      fmpm_pkg::COND_NOT_P0:   take = !stat_i.p0;
      fmpm_pkg::COND_P_LAST:   take = stat_i.p_last;
      fmpm_pkg::COND_RED_MORE: take = stat_i.red_more;
      default:                 take = 1'b0;
    endcase
    upc_d = take ? ctrl_o.target : upc_q + fmpm_pkg::UPC_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= fmpm_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // while busy, the only step that repeats itself is a remainder iteration
  `FMPM_ASSERT(a_hold_only_reduce, busy_o && $stable(upc_q) |-> ctrl_o.red_run, "step held outside remainder loop")

endmodule

@@ design/fibonacci_matrix_power_mod.sv @@
// Top level: Fibonacci number modulo a register value by 2x2 matrix powers.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  input     index_i                                 start high while busy low
//  result    fib_value_o                             done_o high for one cycle
//  config    psel penable pwrite paddr pwdata        APB write, pready tied high
//            prdata                                  register 0 = modulus
//
// A word with index below 2, or with modulus below 2, goes from the check step straight to the final step.
// Otherwise each set bit of index-1 costs one matrix product and each bit but the
// last one square (the last bit skips its square): each matrix entry is two
// products on the one 30x30 multiplier and a radix-16 remainder, three entries per
// matrix product.
// busy drops in the cycle the result is shown, so the next word can start then.
// The receiver takes every result; nothing stalls the block. No clearing pass after reset.
`include "fibonacci_matrix_power_mod_macros.svh"

module fibonacci_matrix_power_mod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [fmpm_pkg::INDEX_BITS-1:0]     index_i,
  output logic                                done_o,
  output logic [fmpm_pkg::MOD_BITS-1:0]       fib_value_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fmpm_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [fmpm_pkg::DATA_BITS-1:0]      pwdata,
  output logic [fmpm_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  logic [fmpm_pkg::MOD_REG_BITS-1:0] modulus_q;
  logic [fmpm_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                              wr_en;
  logic                              accept;
  fmpm_pkg::fmpm_ctrl_t              ctrl;
  fmpm_pkg::fmpm_stat_t              stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[fmpm_pkg::PADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == fmpm_pkg::REG_MODULUS) ?
                   fmpm_pkg::DATA_BITS'(modulus_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= fmpm_pkg::MODULUS_RESET;
    end else if (wr_en && (reg_idx == fmpm_pkg::REG_MODULUS)) begin
      modulus_q <= pwdata[fmpm_pkg::MOD_REG_BITS-1:0];
    end
  end

  fmpm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .stat_i   (stat),
    .ctrl_o   (ctrl),
    .accept_o (accept),
    .busy_o   (busy)
  );

  fmpm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .accept_i    (accept),
    .index_i     (index_i),
    .modulus_i   (modulus_q),
    .stat_o      (stat),
    .done_o      (done_o),
    .fib_value_o (fib_value_o)
  );

endmodule
